### rtl/core/sdsch_pkg.sv
package sdsch_pkg;

  localparam int ID_W      = 4;
  localparam int ID_NUM    = 16;
  localparam int CFG_W     = 5;
  localparam int FTRK_W    = 16;
  localparam int CMP_W     = 8;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [1:0] REG_QUEUE_LIMIT     = 2'd0;
  localparam logic [1:0] REG_REQUESTER_COUNT = 2'd1;
  localparam logic [1:0] REG_START_HEAD      = 2'd2;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   requester_id;
    logic [FTRK_W-1:0] track;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              served_valid;
    logic [ID_W-1:0]   served_requester;
    logic [FTRK_W-1:0] served_track;
    logic [FTRK_W-1:0] head_track;
  } out_t;

  typedef struct packed {
    logic            finish;
    logic            id_ok;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic              ld_count;
    logic              ld_head;
    logic [CFG_W-1:0]  count;
    logic [FTRK_W-1:0] head;
  } cfg_ld_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_LAST,
    BK_MOVE,
    BK_REPLY
  } back_state_e;

endpackage

### rtl/core/sdsch_ram.sv
module sdsch_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/sdsch_front.sv
module sdsch_front
  import sdsch_pkg::*;
#(
  parameter int TRACK_BITS     = 16,
  parameter int MAX_REQUESTERS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_t                   in_data_i,
  input  logic [CFG_W-1:0]      req_count_i,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  output logic [TRACK_BITS-1:0] trk_o,
  input  logic                  cmd_pop_i
);

  cmd_t                  cmd_q [2];
  logic [TRACK_BITS-1:0] trk_q [2];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            fill_q, fill_d;
  logic                  do_push;
  logic                  do_pop;
  cmd_t                  cmd_new;

  assign full        = (fill_q == 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_new.finish = (in_data_i.opcode == OP_FINISH);
    cmd_new.id     = in_data_i.requester_id;
    cmd_new.id_ok  = (CMP_W'(in_data_i.requester_id) < CMP_W'(MAX_REQUESTERS)) &&
                     (CMP_W'(in_data_i.requester_id) < CMP_W'(req_count_i));
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q] <= cmd_new;
      trk_q[wr_ptr_q] <= TRACK_BITS'(in_data_i.track);
    end
  end

  assign cmd_o = cmd_q[rd_ptr_q];
  assign trk_o = trk_q[rd_ptr_q];

endmodule

### rtl/core/sdsch_back.sv
module sdsch_back
  import sdsch_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 16,
  parameter int MAX_REQUESTERS = 16,
  parameter int TRACK_BITS     = 16,
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  input  logic [TRACK_BITS-1:0] trk_i,
  output logic                  cmd_pop_o,
  input  logic [CNT_W-1:0]      lim_i,
  input  cfg_ld_t               cfg_ld_i,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  out_data_o
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int ENT_W = ID_W + TRACK_BITS;
  localparam logic [CFG_W-1:0] LIV_RST =
    (MAX_REQUESTERS < 16) ? CFG_W'(MAX_REQUESTERS) : CFG_W'(16);

  back_state_e           state_q, state_d;
  cmd_t                  op_q, op_d;
  logic [TRACK_BITS-1:0] trk_q, trk_d;
  logic [1:0]            status_q, status_d;
  logic                  served_q, served_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [ID_NUM-1:0]     pend_q, pend_d;
  logic [CFG_W-1:0]      liv_q, liv_d;
  logic [TRACK_BITS-1:0] head_q, head_d;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic                  rdv_q, rdv_d;
  logic [IDX_W-1:0]      rdtag_q, rdtag_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [ID_W-1:0]       best_req_q, best_req_d;
  logic [TRACK_BITS-1:0] best_trk_q, best_trk_d;
  logic [TRACK_BITS-1:0] best_dist_q, best_dist_d;
  logic [ENT_W-1:0]      last_q, last_d;
  out_t                  res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ENT_W-1:0]      rd_data;

  logic [TRACK_BITS-1:0] rd_trk;
  logic [TRACK_BITS-1:0] rd_dist;
  logic [CNT_W-1:0]      cnt_n;
  logic [CFG_W-1:0]      liv_n;
  logic [CMP_W-1:0]      thr;
  logic                  serve;
  logic                  res_free;

  sdsch_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_trk   = rd_data[TRACK_BITS-1:0];
  assign rd_dist  = (head_q >= rd_trk) ? (head_q - rd_trk) : (rd_trk - head_q);
  assign res_free = !res_valid_q || pop;
  assign empty      = !res_valid_q;
  assign out_data_o = res_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    trk_d       = trk_q;
    status_d    = status_q;
    served_d    = served_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    liv_d       = liv_q;
    head_d      = head_q;
    scan_d      = scan_q;
    rdv_d       = 1'b0;
    rdtag_d     = rdtag_q;
    best_idx_d  = best_idx_q;
    best_req_d  = best_req_q;
    best_trk_d  = best_trk_q;
    best_dist_d = best_dist_q;
    last_d      = last_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop;
    cmd_pop_o   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = IDX_W'(cnt_q);
    wr_data     = {op_q.id, trk_q};
    rd_en       = 1'b0;
    rd_addr     = scan_q;
    cnt_n       = cnt_q;
    liv_n       = liv_q;
    thr         = '0;
    serve       = 1'b0;

    if (rdv_q) begin
      if (rdtag_q == '0 || rd_dist < best_dist_q) begin
        best_idx_d  = rdtag_q;
        best_req_d  = rd_data[ENT_W-1:TRACK_BITS];
        best_trk_d  = rd_trk;
        best_dist_d = rd_dist;
      end
      if (CNT_W'(rdtag_q) + CNT_W'(1) == cnt_q) begin
        last_d = rd_data;
      end
    end

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i;
          trk_d     = trk_i;
          state_d   = BK_EXEC;
        end
      end
      BK_EXEC: begin
        status_d = ST_OK;
        if (op_q.finish) begin
          if (liv_q != '0) begin
            liv_n = liv_q - CFG_W'(1);
          end
        end else if (!op_q.id_ok) begin
          status_d = ST_BAD;
        end else if (pend_q[op_q.id]) begin
          status_d = ST_BUSY;
        end else if (cnt_q >= lim_i) begin
          status_d = ST_FULL;
        end else begin
          wr_en              = 1'b1;
          cnt_n              = cnt_q + CNT_W'(1);
          pend_d[op_q.id]    = 1'b1;
        end
        cnt_d = cnt_n;
        liv_d = liv_n;
        thr   = (CMP_W'(liv_n) < CMP_W'(lim_i)) ? CMP_W'(liv_n) : CMP_W'(lim_i);
        serve = (cnt_n != '0) && (CMP_W'(cnt_n) >= thr);
        served_d = serve;
        scan_d   = '0;
        state_d  = serve ? BK_SCAN : BK_REPLY;
      end
      BK_SCAN: begin
        rd_en   = 1'b1;
        rdv_d   = 1'b1;
        rdtag_d = scan_q;
        if (CNT_W'(scan_q) + CNT_W'(1) == cnt_q) begin
          state_d = BK_LAST;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      BK_LAST: begin
        state_d = BK_MOVE;
      end
      BK_MOVE: begin
        wr_en              = 1'b1;
        wr_addr            = best_idx_q;
        wr_data            = last_q;
        cnt_d              = cnt_q - CNT_W'(1);
        pend_d[best_req_q] = 1'b0;
        head_d             = best_trk_q;
        state_d            = BK_REPLY;
      end
      BK_REPLY: begin
        if (res_free) begin
          res_d.status           = status_q;
          res_d.served_valid     = served_q;
          res_d.served_requester = served_q ? best_req_q : '0;
          res_d.served_track     = served_q ? FTRK_W'(best_trk_q) : '0;
          res_d.head_track       = FTRK_W'(head_q);
          res_valid_d            = 1'b1;
          state_d                = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (cfg_ld_i.ld_count) begin
      liv_d = cfg_ld_i.count;
    end
    if (cfg_ld_i.ld_head) begin
      head_d = TRACK_BITS'(cfg_ld_i.head);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      pend_q      <= '0;
      liv_q       <= LIV_RST;
      head_q      <= '0;
      rdv_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      liv_q       <= liv_d;
      head_q      <= head_d;
      rdv_q       <= rdv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    trk_q       <= trk_d;
    status_q    <= status_d;
    served_q    <= served_d;
    scan_q      <= scan_d;
    rdtag_q     <= rdtag_d;
    best_idx_q  <= best_idx_d;
    best_req_q  <= best_req_d;
    best_trk_q  <= best_trk_d;
    best_dist_q <= best_dist_d;
    last_q      <= last_d;
    res_q       <= res_d;
  end

endmodule

### rtl/core/sstf_disk_request_scheduler_unit.sv
// Flow: an accepted push waits in the front FIFO; the back end then runs EXEC and, when
// it serves, SCAN over the N entries of the request table, LAST and MOVE before REPLY.
// The back end takes one item at a time, and REPLY waits until the result register is free;
// the scan reads the request table through its single RAM read port, one entry per cycle.
// Reset: control state and registers return to defaults at once; the table
// RAM is not cleared and no clearing pass runs.
module sstf_disk_request_scheduler_unit
  import sdsch_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 16,
  parameter int MAX_REQUESTERS = 16,
  parameter int TRACK_BITS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_t                in_data_i,
  output logic               empty,
  input  logic               pop,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CFG_W-1:0] RC_RST =
    (MAX_REQUESTERS < 16) ? CFG_W'(MAX_REQUESTERS) : CFG_W'(16);

  logic [CFG_W-1:0]      qlim_q;
  logic [CFG_W-1:0]      rcnt_q;
  logic [FTRK_W-1:0]     shead_q;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;
  logic [CFG_W-1:0]      rcnt_wr;
  logic [CNT_W-1:0]      lim;
  cfg_ld_t               cfg_ld;
  logic                  cmd_valid;
  cmd_t                  cmd;
  logic [TRACK_BITS-1:0] cmd_trk;
  logic                  cmd_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign rcnt_wr = (CMP_W'(pwdata[CFG_W-1:0]) > CMP_W'(MAX_REQUESTERS)) ?
                   CFG_W'(MAX_REQUESTERS) : pwdata[CFG_W-1:0];

  always_comb begin
    if (qlim_q == '0) begin
      lim = CNT_W'(1);
    end else if (CMP_W'(qlim_q) > CMP_W'(QUEUE_DEPTH)) begin
      lim = CNT_W'(QUEUE_DEPTH);
    end else begin
      lim = CNT_W'(qlim_q);
    end
  end

  always_comb begin
    cfg_ld.ld_count = cfg_wr && (reg_idx == REG_REQUESTER_COUNT);
    cfg_ld.ld_head  = cfg_wr && (reg_idx == REG_START_HEAD);
    cfg_ld.count    = rcnt_wr;
    cfg_ld.head     = pwdata[FTRK_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlim_q  <= CFG_W'(16);
      rcnt_q  <= RC_RST;
      shead_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QUEUE_LIMIT:     qlim_q  <= pwdata[CFG_W-1:0];
        REG_REQUESTER_COUNT: rcnt_q  <= rcnt_wr;
        REG_START_HEAD:      shead_q <= pwdata[FTRK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUEUE_LIMIT:     prdata = PDATA_W'(qlim_q);
      REG_REQUESTER_COUNT: prdata = PDATA_W'(rcnt_q);
      REG_START_HEAD:      prdata = PDATA_W'(shead_q);
      default:             prdata = '0;
    endcase
  end

  sdsch_front #(
    .TRACK_BITS     (TRACK_BITS),
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .req_count_i (rcnt_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .trk_o       (cmd_trk),
    .cmd_pop_i   (cmd_pop)
  );

  sdsch_back #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_REQUESTERS (MAX_REQUESTERS),
    .TRACK_BITS     (TRACK_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .trk_i       (cmd_trk),
    .cmd_pop_o   (cmd_pop),
    .lim_i       (lim),
    .cfg_ld_i    (cfg_ld),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdsch_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 1900;

  logic               clk      = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               push     = 1'b0;
  logic               full;
  in_t                in_data  = '0;
  logic               empty;
  logic               pop      = 1'b0;
  out_t               out_data;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // scheduler shadow state
  logic [ID_W-1:0]   slot_req [TABLE_DEPTH];
  logic [FTRK_W-1:0] slot_trk [TABLE_DEPTH];
  int                slot_cnt  = 0;
  logic [ID_NUM-1:0] busy_mask = '0;
  int                live_cnt  = 16;
  int                count_reg = 16;
  int                limit_reg = 16;
  logic [FTRK_W-1:0] arm_pos   = '0;

  out_t reply_q[$];
  int   fail_cnt   = 0;
  bit   no_gaps    = 1'b0;
  bit   pop_steady = 1'b0;
  int   pop_hold   = 0;
  int   pop_roll;

  sstf_disk_request_scheduler_unit #(
    .QUEUE_DEPTH   (TABLE_DEPTH),
    .MAX_REQUESTERS(ID_NUM),
    .TRACK_BITS    (FTRK_W)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic out_t schedule_item(in_t it);
    out_t r;
    int   lim;
    int   thr;
    int   best;
    int   db;
    int   dk;
    r = '0;
    r.status = ST_OK;
    lim = (limit_reg < 1) ? 1 : (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
    if (it.opcode == OP_SUBMIT) begin
      if (int'(it.requester_id) >= count_reg) begin
        r.status = ST_BAD;
      end else if (busy_mask[it.requester_id]) begin
        r.status = ST_BUSY;
      end else if (slot_cnt >= lim) begin
        r.status = ST_FULL;
      end else begin
        slot_req[slot_cnt] = it.requester_id;
        slot_trk[slot_cnt] = it.track;
        slot_cnt++;
        busy_mask[it.requester_id] = 1'b1;
      end
    end else if (live_cnt > 0) begin
      live_cnt--;
    end
    thr = (live_cnt < lim) ? live_cnt : lim;
    if (slot_cnt > 0 && slot_cnt >= thr) begin
      best = 0;
      for (int k = 1; k < slot_cnt; k++) begin
        db = int'(arm_pos) - int'(slot_trk[best]);
        dk = int'(arm_pos) - int'(slot_trk[k]);
        if (db < 0) db = -db;
        if (dk < 0) dk = -dk;
        if (db > dk) best = k;
      end
      r.served_valid     = 1'b1;
      r.served_requester = slot_req[best];
      r.served_track     = slot_trk[best];
      arm_pos            = slot_trk[best];
      busy_mask[slot_req[best]] = 1'b0;
      slot_req[best] = slot_req[slot_cnt-1];
      slot_trk[best] = slot_trk[slot_cnt-1];
      slot_cnt--;
    end
    r.head_track = arm_pos;
    return r;
  endfunction

  task automatic push_request(logic op, logic [ID_W-1:0] id, logic [FTRK_W-1:0] trk);
    in_t it;
    int  r;
    int  gap;
    it.opcode       = op;
    it.requester_id = id;
    it.track        = trk;
    in_data <= it;
    push    <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    reply_q = {reply_q, schedule_item(it)};
    @(negedge clk);
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_replies();
    push <= 1'b0;
    do @(negedge clk); while (reply_q.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_QUEUE_LIMIT: limit_reg = int'(val[CFG_W-1:0]);
      REG_REQUESTER_COUNT: begin
        count_reg = (val[CFG_W-1:0] > ID_NUM) ? ID_NUM : int'(val[CFG_W-1:0]);
        live_cnt  = count_reg;
      end
      REG_START_HEAD: arm_pos = val[FTRK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // reset defaults: limit 16, all requesters live, nothing served
  task automatic test_defaults();
    push_request(OP_SUBMIT, 4'd15, 16'hFFFF);
    push_request(OP_SUBMIT, 4'd0, 16'h0000);
    push_request(OP_SUBMIT, 4'd15, 16'h0005);
  endtask

  // equal seek distance on both sides of the head: lower slot wins
  task automatic test_tie_break();
    drain_replies();
    write_reg(REG_START_HEAD, 32'd100);
    write_reg(REG_REQUESTER_COUNT, 32'd5);
    push_request(OP_SUBMIT, 4'd3, 16'd110);
    push_request(OP_SUBMIT, 4'd4, 16'd90);
    push_request(OP_SUBMIT, 4'd1, 16'd200);
  endtask

  // bad id beats busy, busy beats full; shrink the limit under a loaded table
  task automatic test_check_order();
    push_request(OP_SUBMIT, 4'd15, 16'd7);
    drain_replies();
    write_reg(REG_QUEUE_LIMIT, 32'd2);
    push_request(OP_SUBMIT, 4'd0, 16'd1);
    push_request(OP_SUBMIT, 4'd2, 16'h8000);
    push_request(OP_SUBMIT, 4'd2, 16'h8001);
  endtask

  // finish beats run live count down to zero, where it stays, and drain the table
  task automatic test_finish_drain();
    drain_replies();
    write_reg(REG_QUEUE_LIMIT, 32'd16);
    push_request(OP_SUBMIT, 4'd2, 16'h1234);
    push_request(OP_SUBMIT, 4'd3, 16'h00FF);
    repeat (6) push_request(OP_FINISH, 4'hF, 16'hFFFF);
  endtask

  task automatic test_register_clamps();
    drain_replies();
    write_reg(REG_QUEUE_LIMIT, 32'd0);
    write_reg(REG_REQUESTER_COUNT, 32'd31);
    write_reg(REG_START_HEAD, 32'h0000_FFFF);
    push_request(OP_SUBMIT, 4'd9, 16'hFFFF);
    push_request(OP_SUBMIT, 4'd0, 16'hFFFE);
    drain_replies();
    write_reg(REG_QUEUE_LIMIT, 32'd31);
    push_request(OP_SUBMIT, 4'd12, 16'h0001);
    drain_replies();
    write_reg(REG_REQUESTER_COUNT, 32'd0);
    push_request(OP_SUBMIT, 4'd0, 16'h4000);
  endtask

  task automatic test_random();
    int                sent;
    int                phase_len;
    int                r;
    int                k;
    int                m;
    int                free_ids[$];
    logic              op;
    logic [ID_W-1:0]   id;
    logic [FTRK_W-1:0] trk;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_replies();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(REG_QUEUE_LIMIT, 32'd0);
          1:       write_reg(REG_QUEUE_LIMIT, 32'd31);
          2:       write_reg(REG_QUEUE_LIMIT, 32'd1);
          default: write_reg(REG_QUEUE_LIMIT, $urandom_range(2, 16));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_REQUESTER_COUNT, 32'd0);
          1:       write_reg(REG_REQUESTER_COUNT, 32'd31);
          2:       write_reg(REG_REQUESTER_COUNT, 32'd17);
          3:       write_reg(REG_REQUESTER_COUNT, 32'd1);
          default: write_reg(REG_REQUESTER_COUNT, $urandom_range(2, 16));
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_START_HEAD, 32'd0);
          1:       write_reg(REG_START_HEAD, 32'h0000_FFFF);
          default: write_reg(REG_START_HEAD, $urandom_range(0, 65535));
        endcase
      end
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        r   = $urandom_range(0, 99);
        op  = OP_SUBMIT;
        id  = ID_W'($urandom_range(0, ID_NUM - 1));
        trk = FTRK_W'($urandom_range(0, 65535));
        if (r < 75) begin
          free_ids.delete();
          for (int i = 0; i < count_reg; i++) if (!busy_mask[i]) free_ids = {free_ids, i};
          if (free_ids.size() == 0) begin
            op = OP_FINISH;
          end else begin
            id = ID_W'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
            r  = $urandom_range(0, 99);
            if (r < 20) begin
              trk = FTRK_W'(int'(arm_pos) + int'($urandom_range(0, 8)) - 4);
            end else if (r < 35 && slot_cnt > 0) begin
              k   = $urandom_range(0, slot_cnt - 1);
              m   = 2 * int'(arm_pos) - int'(slot_trk[k]);
              trk = (m >= 0 && m <= 65535) ? m[FTRK_W-1:0] : slot_trk[k];
            end else if (r < 45) begin
              trk = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
          end
        end else if (r < 87) begin
          op = OP_FINISH;
        end
        push_request(op, id, trk);
      end
      sent += phase_len;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop_roll = $urandom_range(0, 99);
        if (pop_steady || pop_roll < 65) begin
          pop <= 1'b1;
        end else if (pop_roll < 96) begin
          pop <= 1'b0;
        end else begin
          pop_hold = $urandom_range(10, 40);
          pop <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) pop_steady = !pop_steady;
    end
  end

  always @(posedge clk) begin : check_replies
    out_t want;
    if (rst_ni && pop === 1'b1 && empty === 1'b0) begin
      if (reply_q.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected beat: got %p", out_data);
        fail_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (out_data.status !== want.status ||
            out_data.served_valid !== want.served_valid ||
            out_data.served_requester !== want.served_requester ||
            out_data.served_track !== want.served_track ||
            out_data.head_track !== want.head_track) begin
          if (fail_cnt < 10) $display("mismatch: expected %p, got %p", want, out_data);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    test_defaults();
    test_tie_break();
    test_check_order();
    test_finish_drain();
    test_register_clamps();
    test_random();
    drain_replies();
    repeat (40) @(negedge clk);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
